@@ rtl/fhe_pkg.sv @@
// ----------------------------------------------------------------------------
// Flame heat effect package
// Shared widths, register indexes, transaction structs and arithmetic helpers.
// ----------------------------------------------------------------------------
package fhe_pkg;

   localparam int NumCells = 7;
   localparam int IdxW     = 3;
   localparam int HeatW    = 8;
   localparam int CoolW    = 5;
   localparam int CsrIdxW  = 1;
   localparam int CsrDataW = 8;

   localparam logic [IdxW-1:0]     LastCell       = IdxW'(NumCells - 1);
   localparam logic [CsrIdxW-1:0]  CsrPalette     = CsrIdxW'(0);
   localparam logic [CsrIdxW-1:0]  CsrThreshold   = CsrIdxW'(1);
   localparam logic [CsrDataW-1:0] ThresholdReset = 8'd160;

   // candle palette
   localparam logic [15:0] CandleScale = 16'd191;
   localparam logic [7:0]  CandleHigh  = 8'h80;
   localparam logic [7:0]  CandleMid   = 8'h40;
   localparam logic [7:0]  CandleMask  = 8'h3F;
   localparam logic [7:0]  CandleHiG   = 8'd50;
   localparam logic [7:0]  CandleMidG  = 8'd40;

   // propane palette
   localparam logic [7:0] PropLow    = 8'd60;
   localparam logic [7:0] PropMid    = 8'd140;
   localparam logic [7:0] PropHigh   = 8'd220;
   localparam logic [7:0] PropMidB   = 8'd150;
   localparam logic [7:0] PropHighG  = 8'd80;
   localparam logic [7:0] PropTopR   = 8'd40;
   localparam logic [7:0] PropTopG   = 8'd180;
   localparam logic [7:0] FullScale  = 8'd255;

   typedef struct packed {
      logic             rd_en;
      logic [IdxW-1:0]  rd_addr;
      logic             wr_en;
      logic [IdxW-1:0]  wr_addr;
      logic [HeatW-1:0] wr_data;
   } fhe_mem_req_type;

   typedef struct packed {
      logic             valid;
      logic [IdxW-1:0]  index;
      logic [HeatW-1:0] heat;
   } fhe_heat_type;

   typedef struct packed {
      logic            valid;
      logic [IdxW-1:0] index;
      logic [7:0]      red;
      logic [7:0]      green;
      logic [7:0]      blue;
   } fhe_pix_type;

   // floor(x / 3) for x below 256
   function automatic logic [7:0] div3_narrow(input logic [7:0] x);
      logic [15:0] prod;
      prod = 16'(x) * 16'd171;
      return 8'(prod >> 9);
   endfunction

   // floor(x / 3) for x below 768
   function automatic logic [7:0] div3_wide(input logic [9:0] x);
      logic [19:0] prod;
      prod = 20'(x) * 20'd683;
      return 8'(prod >> 11);
   endfunction

endpackage

@@ rtl/fhe_heat_mem.sv @@
// ----------------------------------------------------------------------------
// Flame heat memory
// Seven-entry heat store, one read and one write port, registered read data.
// Entries not yet written since reset read as zero.
// ----------------------------------------------------------------------------
module fhe_heat_mem (
   input  logic                          clock,
   input  logic                          reset,
   input  fhe_pkg::fhe_mem_req_type      mem_req,
   output logic [fhe_pkg::HeatW-1:0]     rd_data
);
   import fhe_pkg::*;

   logic [HeatW-1:0]    mem_ff [NumCells];
   logic [NumCells-1:0] written_ff;
   logic [HeatW-1:0]    rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (mem_req.wr_en) begin
         written_ff[mem_req.wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= written_ff[mem_req.rd_addr] ? mem_ff[mem_req.rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/fhe_palette.sv @@
// ----------------------------------------------------------------------------
// Flame palette
// Two-stage heat to colour mapping: scale, then band selection (propane bands the unscaled heat).
// ----------------------------------------------------------------------------
module fhe_palette (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   palette_select,
   input  fhe_pkg::fhe_heat_type  cell_heat,
   output fhe_pkg::fhe_pix_type   pix
);
   import fhe_pkg::*;

   logic             valid_ff;
   logic [IdxW-1:0]  index_ff;
   logic [HeatW-1:0] heat_ff;
   logic [7:0]       scaled_ff;

   logic [15:0] prod;
   logic [16:0] quot_sum;
   logic [7:0]  scaled_in;

   always_comb begin
      prod      = 16'(cell_heat.heat) * CandleScale;
      quot_sum  = 17'(prod) + 17'(prod >> 8) + 17'd1;
      scaled_in = 8'(quot_sum >> 8);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= cell_heat.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         index_ff  <= cell_heat.index;
         heat_ff   <= cell_heat.heat;
         scaled_ff <= scaled_in;
      end
   end

   logic [7:0] ramp;
   logic [7:0] delta;

   always_comb begin
      ramp      = (scaled_ff & CandleMask) << 2;
      delta     = '0;
      pix.valid = valid_ff;
      pix.index = index_ff;
      pix.red   = '0;
      pix.green = '0;
      pix.blue  = '0;
      if (palette_select) begin
         if (heat_ff < PropLow) begin
            pix.blue = heat_ff << 1;
         end else if (heat_ff < PropMid) begin
            delta     = heat_ff - PropLow;
            pix.green = div3_narrow(delta);
            pix.blue  = PropMidB + delta;
         end else if (heat_ff < PropHigh) begin
            delta     = heat_ff - PropMid;
            pix.red   = delta >> 3;
            pix.green = PropHighG + delta;
            pix.blue  = FullScale;
         end else begin
            delta     = heat_ff - PropHigh;
            pix.red   = PropTopR + delta;
            pix.green = PropTopG + delta;
            pix.blue  = FullScale;
         end
      end else begin
         if (scaled_ff > CandleHigh) begin
            pix.red   = FullScale;
            pix.green = CandleHiG + div3_narrow(ramp);
         end else if (scaled_ff > CandleMid) begin
            pix.red   = FullScale;
            pix.green = ramp + CandleMidG;
         end else begin
            pix.red = ramp;
         end
      end
   end

endmodule

@@ rtl/flame_heat_effect.sv @@
// ----------------------------------------------------------------------------
// Flame heat effect
// Seven-cell flame heat model: cool, drift, spark, then palette per pixel.
// ----------------------------------------------------------------------------
// Each accepted frame transaction yields seven pixel transactions, pixel 0
// first, frame_end set on pixel 6. The heat cells live in a seven-entry
// memory with one read port: one cell is read per cycle while the output is
// not stalled, and the next frame is taken only once the last cell has
// cleared the cell update stage. Each cell then passes the heat register,
// the palette scale register and the output register in that order.
// Heat memory entries read as zero after reset until written; no clearing
// pass is needed. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module flame_heat_effect (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [fhe_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [fhe_pkg::CsrDataW-1:0]   csr_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [fhe_pkg::CoolW-1:0]      req_cool_0,
   input  logic [fhe_pkg::CoolW-1:0]      req_cool_1,
   input  logic [fhe_pkg::CoolW-1:0]      req_cool_2,
   input  logic [fhe_pkg::CoolW-1:0]      req_cool_3,
   input  logic [fhe_pkg::CoolW-1:0]      req_cool_4,
   input  logic [fhe_pkg::CoolW-1:0]      req_cool_5,
   input  logic [fhe_pkg::CoolW-1:0]      req_cool_6,
   input  logic [7:0]                     req_spark_draw,
   input  logic                           req_spark_cell,
   input  logic [7:0]                     req_spark_amount,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [fhe_pkg::IdxW-1:0]       rsp_pixel_index,
   output logic [7:0]                     rsp_red,
   output logic [7:0]                     rsp_green,
   output logic [7:0]                     rsp_blue,
   output logic                           rsp_frame_end
);
   import fhe_pkg::*;

   logic             palette_ff;
   logic [7:0]       threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         palette_ff   <= 1'b0;
         threshold_ff <= ThresholdReset;
      end else if (csr_write) begin
         case (csr_index)
            CsrPalette:   palette_ff   <= csr_data[0];
            CsrThreshold: threshold_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic advance;
   logic accept;
   logic busy_ff;
   logic [IdxW-1:0] idx_ff;
   logic cell_valid_ff;
   logic [IdxW-1:0] cell_idx_ff;

   logic [CoolW-1:0] cool_ff [NumCells];
   logic             fire_ff;
   logic             spark_cell_ff;
   logic [7:0]       amount_ff;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = !busy_ff && !cell_valid_ff;
   assign accept    = req_valid && req_ready;

   // latch the frame transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         cool_ff[0]    <= req_cool_0;
         cool_ff[1]    <= req_cool_1;
         cool_ff[2]    <= req_cool_2;
         cool_ff[3]    <= req_cool_3;
         cool_ff[4]    <= req_cool_4;
         cool_ff[5]    <= req_cool_5;
         cool_ff[6]    <= req_cool_6;
         fire_ff       <= req_spark_draw < threshold_ff;
         spark_cell_ff <= req_spark_cell;
         amount_ff     <= req_spark_amount;
      end
   end

   // issue one cell read per cycle while the output is not stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (accept) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (busy_ff && advance) begin
         idx_ff <= idx_ff + 1'b1;
         if (idx_ff == LastCell) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_valid_ff <= 1'b0;
      end else if (advance) begin
         cell_valid_ff <= busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cell_idx_ff <= idx_ff;
      end
   end

   fhe_mem_req_type  mem_req;
   logic [HeatW-1:0] rd_data;
   logic [HeatW-1:0] cooled;
   logic [HeatW-1:0] heat_in;
   logic [HeatW-1:0] prev1_ff;
   logic [HeatW-1:0] prev2_ff;
   logic [9:0]       drift_sum;
   logic [8:0]       spark_sum;
   logic [CoolW-1:0] cool_sel;

   fhe_heat_mem u_heat_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // cool, drift and spark for the cell in flight
   always_comb begin
      cool_sel  = cool_ff[cell_idx_ff];
      cooled    = (rd_data > HeatW'(cool_sel)) ? rd_data - HeatW'(cool_sel) : '0;
      drift_sum = 10'(prev1_ff) + {1'b0, prev2_ff, 1'b0};
      spark_sum = 9'(cooled) + 9'(amount_ff);
      if (cell_idx_ff > IdxW'(1)) begin
         heat_in = div3_wide(drift_sum);
      end else if (fire_ff && (spark_cell_ff == cell_idx_ff[0])) begin
         heat_in = spark_sum[8] ? FullScale : spark_sum[7:0];
      end else begin
         heat_in = cooled;
      end
      mem_req.rd_en   = busy_ff && advance;
      mem_req.rd_addr = idx_ff;
      mem_req.wr_en   = cell_valid_ff && advance;
      mem_req.wr_addr = cell_idx_ff;
      mem_req.wr_data = heat_in;
   end

   // hold the two cooled cells below for the drift
   always_ff @(posedge clock) begin
      if (cell_valid_ff && advance) begin
         prev2_ff <= prev1_ff;
         prev1_ff <= cooled;
      end
   end

   fhe_heat_type heat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         heat_ff.valid <= 1'b0;
      end else if (advance) begin
         heat_ff.valid <= cell_valid_ff;
      end
      if (advance) begin
         heat_ff.index <= cell_idx_ff;
         heat_ff.heat  <= heat_in;
      end
   end

   fhe_pix_type pix;

   fhe_palette u_palette (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .palette_select (palette_ff),
      .cell_heat      (heat_ff),
      .pix            (pix)
   );

   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= pix.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pixel_index <= pix.index;
         rsp_red         <= pix.red;
         rsp_green       <= pix.green;
         rsp_blue        <= pix.blue;
         rsp_frame_end   <= pix.index == LastCell;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Flame heat effect testbench
// Drives frame transactions into the flame block and predicts the heat cells
// and palette colours. Every pixel transaction is checked against the oldest
// expected pixel. Directed frames cover the colour bands, saturation, heavy
// cooling and a zero spark threshold. Random frames then run under several
// patterns of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb;
   import fhe_pkg::*;

   typedef enum logic {Candle = 1'b0, Propane = 1'b1} palette_type;

   typedef struct packed {
      logic [NumCells-1:0][CoolW-1:0] cool;
      logic [7:0]                     spark_draw;
      logic                           spark_cell;
      logic [7:0]                     spark_amount;
   } frame_type;

   typedef struct packed {
      logic [IdxW-1:0] pixel_index;
      logic [7:0]      red;
      logic [7:0]      green;
      logic [7:0]      blue;
      logic            frame_end;
   } pixel_type;

   localparam int StallLimit = 2000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_write = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [CsrDataW-1:0] csr_data = '0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [CoolW-1:0]    req_cool_0 = '0;
   logic [CoolW-1:0]    req_cool_1 = '0;
   logic [CoolW-1:0]    req_cool_2 = '0;
   logic [CoolW-1:0]    req_cool_3 = '0;
   logic [CoolW-1:0]    req_cool_4 = '0;
   logic [CoolW-1:0]    req_cool_5 = '0;
   logic [CoolW-1:0]    req_cool_6 = '0;
   logic [7:0]          req_spark_draw = '0;
   logic                req_spark_cell = 1'b0;
   logic [7:0]          req_spark_amount = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [IdxW-1:0]     rsp_pixel_index;
   logic [7:0]          rsp_red;
   logic [7:0]          rsp_green;
   logic [7:0]          rsp_blue;
   logic                rsp_frame_end;

   logic [HeatW-1:0] flame_heat [NumCells] = '{default: '0};
   palette_type      palette_sel = Candle;
   logic [7:0]       spark_threshold = ThresholdReset;
   pixel_type        pending_pixels [$];
   int               fail_count = 0;
   int               req_idle_pct = 0;
   int               rsp_stall_pct = 0;
   int               quiet_cycles = 0;

   flame_heat_effect dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cool_0       (req_cool_0),
      .req_cool_1       (req_cool_1),
      .req_cool_2       (req_cool_2),
      .req_cool_3       (req_cool_3),
      .req_cool_4       (req_cool_4),
      .req_cool_5       (req_cool_5),
      .req_cool_6       (req_cool_6),
      .req_spark_draw   (req_spark_draw),
      .req_spark_cell   (req_spark_cell),
      .req_spark_amount (req_spark_amount),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_index  (rsp_pixel_index),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_frame_end    (rsp_frame_end)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic pixel_type candle_colour(input logic [7:0] h);
      int unsigned s;
      int unsigned ramp;
      pixel_type   p;
      p    = '0;
      s    = int'(h) * 191 / 255;
      ramp = (s & 'h3F) << 2;
      if (s > 'h80) begin
         p.red   = 8'd255;
         p.green = 8'(50 + ramp / 3);
      end else if (s > 'h40) begin
         p.red   = 8'd255;
         p.green = 8'(ramp + 40);
      end else begin
         p.red = 8'(ramp);
      end
      return p;
   endfunction

   function automatic pixel_type propane_colour(input logic [7:0] h);
      int unsigned t;
      pixel_type   p;
      p = '0;
      t = 32'(h);
      if (t < 60) begin
         p.blue = 8'(2 * t);
      end else if (t < 140) begin
         p.green = 8'((t - 60) / 3);
         p.blue  = 8'(150 + (t - 60));
      end else if (t < 220) begin
         p.red   = 8'((t - 140) / 8);
         p.green = 8'(80 + (t - 140));
         p.blue  = 8'd255;
      end else begin
         p.red   = 8'(40 + (t - 220));
         p.green = 8'(180 + (t - 220));
         p.blue  = 8'd255;
      end
      return p;
   endfunction

   // cool, drift upward from the top, spark, then queue the seven pixels
   function automatic void advance_flame(input frame_type f);
      int          i;
      int unsigned v;
      pixel_type   p;
      for (i = 0; i < NumCells; i++)
         flame_heat[i] = (flame_heat[i] > 8'(f.cool[i])) ? flame_heat[i] - 8'(f.cool[i])
                                                         : 8'd0;
      for (i = NumCells - 1; i >= 2; i--)
         flame_heat[i] = 8'((int'(flame_heat[i-1]) + 2 * int'(flame_heat[i-2])) / 3);
      if (f.spark_draw < spark_threshold) begin
         v = int'(flame_heat[f.spark_cell]) + int'(f.spark_amount);
         flame_heat[f.spark_cell] = (v > 255) ? 8'd255 : 8'(v);
      end
      for (i = 0; i < NumCells; i++) begin
         p = (palette_sel == Propane) ? propane_colour(flame_heat[i])
                                      : candle_colour(flame_heat[i]);
         p.pixel_index = IdxW'(i);
         p.frame_end   = (i == int'(LastCell));
         pending_pixels.push_back(p);
      end
   endfunction

   function automatic frame_type flat_frame(input int cool, input int draw, input int spark_sel,
                                            input int amount);
      frame_type f;
      int        i;
      for (i = 0; i < NumCells; i++)
         f.cool[i] = CoolW'(cool);
      f.spark_draw   = 8'(draw);
      f.spark_cell   = spark_sel[0];
      f.spark_amount = 8'(amount);
      return f;
   endfunction

   function automatic frame_type random_frame();
      frame_type f;
      int        i;
      for (i = 0; i < NumCells; i++)
         f.cool[i] = ($urandom_range(4) == 0) ? CoolW'($urandom_range(31))
                                              : CoolW'($urandom_range(24));
      f.spark_draw   = 8'($urandom_range(255));
      f.spark_cell   = 1'($urandom_range(1));
      f.spark_amount = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                : 8'($urandom_range(254, 160));
      return f;
   endfunction

   task automatic send_frame(input frame_type f);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_cool_0       <= f.cool[0];
      req_cool_1       <= f.cool[1];
      req_cool_2       <= f.cool[2];
      req_cool_3       <= f.cool[3];
      req_cool_4       <= f.cool[4];
      req_cool_5       <= f.cool[5];
      req_cool_6       <= f.cool[6];
      req_spark_draw   <= f.spark_draw;
      req_spark_cell   <= f.spark_cell;
      req_spark_amount <= f.spark_amount;
      do
         @(posedge clock);
      while (!req_ready);
      advance_flame(f);
   endtask

   // hold off the sender until every pixel has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_config(input palette_type pal, input logic [7:0] thr);
      csr_write <= 1'b1;
      csr_index <= CsrPalette;
      csr_data  <= CsrDataW'(pal);
      @(posedge clock);
      csr_index <= CsrThreshold;
      csr_data  <= thr;
      @(posedge clock);
      csr_write       <= 1'b0;
      palette_sel     = pal;
      spark_threshold = thr;
   endtask

   task automatic set_idling(input int req_pct, input int rsp_pct);
      req_idle_pct  = req_pct;
      rsp_stall_pct = rsp_pct;
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   task automatic test_reset_state();
      set_config(Candle, ThresholdReset);
      send_frame(flat_frame(0, 255, 0, 200));
      drain();
   endtask

   task automatic test_candle_bands();
      set_config(Candle, 8'd255);
      send_frame(flat_frame(0, 0, 0, 90));
      send_frame(flat_frame(0, 0, 0, 90));
      send_frame(flat_frame(0, 0, 1, 120));
      send_frame(flat_frame(2, 10, 0, 254));
      send_frame(flat_frame(5, 100, 1, 60));
      send_frame(flat_frame(0, 254, 0, 0));
      drain();
   endtask

   task automatic test_propane_bands();
      set_config(Propane, 8'd255);
      send_frame(flat_frame(24, 0, 0, 59));
      send_frame(flat_frame(0, 0, 1, 100));
      send_frame(flat_frame(1, 0, 0, 160));
      send_frame(flat_frame(0, 0, 0, 254));
      send_frame(flat_frame(3, 200, 1, 255));
      send_frame(flat_frame(16, 254, 0, 0));
      drain();
   endtask

   task automatic test_full_spark();
      set_config(Candle, 8'd255);
      send_frame(flat_frame(0, 0, 0, 255));
      send_frame(flat_frame(0, 0, 0, 255));
      send_frame(flat_frame(0, 0, 1, 255));
      drain();
   endtask

   task automatic test_large_cooldown();
      frame_type f;
      f = flat_frame(31, 255, 1, 255);
      f.cool[1] = 5'd24;
      f.cool[2] = 5'd16;
      f.cool[3] = 5'd8;
      f.cool[4] = 5'd1;
      f.cool[5] = 5'd0;
      set_config(Propane, 8'd255);
      send_frame(f);
      send_frame(flat_frame(31, 255, 0, 0));
      send_frame(flat_frame(31, 255, 0, 0));
      drain();
   endtask

   task automatic test_threshold_zero();
      set_config(Propane, 8'd0);
      send_frame(flat_frame(0, 0, 0, 255));
      send_frame(flat_frame(0, 0, 1, 254));
      drain();
   endtask

   task automatic test_random_traffic(input int req_pct, input int rsp_pct);
      logic [7:0] thr;
      int         half;
      int         n;
      set_idling(req_pct, rsp_pct);
      for (half = 0; half < 2; half++) begin
         case ($urandom_range(3))
            0:       thr = 8'd255;
            1:       thr = ThresholdReset;
            default: thr = 8'($urandom_range(255));
         endcase
         set_config(palette_type'($urandom_range(1)), thr);
         for (n = 0; n < 25; n++)
            send_frame(random_frame());
         drain();
      end
   endtask

   always @(posedge clock) begin : pixel_check
      pixel_type got;
      pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_pixel_index, rsp_red, rsp_green, rsp_blue, rsp_frame_end};
         if (pending_pixels.size() == 0) begin
            $error("pixel %0d arrived with no frame outstanding", got.pixel_index);
            fail_count++;
         end else begin
            want = pending_pixels.pop_front();
            check_field("pixel_index", int'(want.pixel_index), int'(got.pixel_index));
            check_field("red", int'(want.red), int'(got.red));
            check_field("green", int'(want.green), int'(got.green));
            check_field("blue", int'(want.blue), int'(got.blue));
            check_field("frame_end", int'(want.frame_end), int'(got.frame_end));
         end
      end
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= StallLimit) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      set_idling(0, 0);
      test_reset_state();
      test_candle_bands();
      test_propane_bands();
      test_full_spark();
      test_large_cooldown();
      test_threshold_zero();
      test_random_traffic(0, 0);
      test_random_traffic(50, 0);
      test_random_traffic(0, 50);
      test_random_traffic(17, 17);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_pixels.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/fhe_pkg.sv
rtl/fhe_heat_mem.sv
rtl/fhe_palette.sv
rtl/flame_heat_effect.sv
tb/tb.sv
